// ===== hdl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Types, constants and fixed-point helpers shared by the particle update core.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int ALPHA_W   = FRAC_BITS + 1;
   localparam int MOT_LAT   = 6;
   localparam int DIV_LAT   = Q_W + 2;
   localparam int ALIGN_LAT = DIV_LAT - MOT_LAT;
   localparam int BLEND_LAT = 3;
   localparam int TOTAL_LAT = DIV_LAT + BLEND_LAT;
   localparam int PROD_W    = 33 + ALPHA_W + 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;

   localparam logic [2:0] CSR_FRAME_TIME = 3'd0;
   localparam logic [2:0] CSR_GRAVITY    = 3'd1;
   localparam logic [2:0] CSR_EMIT_X     = 3'd2;
   localparam logic [2:0] CSR_EMIT_Y     = 3'd3;
   localparam logic [2:0] CSR_EMIT_Z     = 3'd4;

   localparam logic [30:0]        FRAME_TIME_RST = 31'd1092;
   localparam logic signed [31:0] GRAVITY_RST    = -32'sd642908;

   typedef struct packed {
      logic [30:0]        frame_time;
      logic signed [31:0] gravity;
      logic signed [31:0] emit_x;
      logic signed [31:0] emit_y;
      logic signed [31:0] emit_z;
   } psu_cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tgt_x;
      logic signed [31:0] tgt_y;
      logic signed [31:0] tgt_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        elapsed;
      logic [30:0]        life;
      logic signed [31:0] weight;
   } psu_req_type;

   typedef struct packed {
      logic signed [31:0] p_x;
      logic signed [31:0] p_y;
      logic signed [31:0] p_z;
      logic signed [31:0] t_x;
      logic signed [31:0] t_y;
      logic signed [31:0] t_z;
      logic signed [31:0] vel_y;
   } psu_motion_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [30:0]        elapsed;
      logic               alive;
   } psu_time_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tgt_x;
      logic signed [31:0] tgt_y;
      logic signed [31:0] tgt_z;
      logic signed [31:0] vel_y;
      logic [30:0]        elapsed;
      logic               alive;
   } psu_rsp_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // floor toward minus infinity, then clamp
   function automatic logic signed [31:0] floor_sat(input logic signed [63:0] v);
      return sat_s32(v >>> FRAC_BITS);
   endfunction

   function automatic logic signed [31:0] ft_signed(input logic [30:0] ft);
      return $signed({1'b0, ft});
   endfunction

endpackage

// ===== hdl/psu_motion.sv =====
// ----------------------------------------------------------------------------
// psu_motion
// Six-stage pipeline: gravity, velocity and displacement, moved position and
// target.
// ----------------------------------------------------------------------------
module psu_motion (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  psu_pkg::psu_req_type   req,
   input  psu_pkg::psu_cfg_type   cfg,
   output logic                   out_valid,
   output psu_pkg::psu_motion_type out
);

   logic [psu_pkg::MOT_LAT-1:0] valid_ff, valid_in;
   logic signed [31:0] ft_s;

   psu_pkg::psu_req_type a_req_ff, a_req_in, b_req_ff, b_req_in, c_req_ff, c_req_in;
   logic signed [63:0] a_gprod_ff, a_gprod_in;
   logic signed [63:0] b_dvprod_ff, b_dvprod_in, b_dxprod_ff, b_dxprod_in;
   logic signed [63:0] b_dzprod_ff, b_dzprod_in;
   logic signed [31:0] b_gw;
   logic signed [31:0] c_vely_ff, c_vely_in, c_dx_ff, c_dx_in, c_dz_ff, c_dz_in;
   logic signed [63:0] d_yprod_ff, d_yprod_in;
   logic signed [31:0] d_vely_ff, d_vely_in, d_px_ff, d_px_in, d_pz_ff, d_pz_in;
   logic signed [31:0] d_tx_ff, d_tx_in, d_tz_ff, d_tz_in;
   logic signed [31:0] d_posy_ff, d_posy_in, d_tgty_ff, d_tgty_in;
   logic signed [31:0] e_dy_ff, e_dy_in;
   logic signed [31:0] e_vely_ff, e_vely_in, e_px_ff, e_px_in, e_pz_ff, e_pz_in;
   logic signed [31:0] e_tx_ff, e_tx_in, e_tz_ff, e_tz_in;
   logic signed [31:0] e_posy_ff, e_posy_in, e_tgty_ff, e_tgty_in;
   psu_pkg::psu_motion_type f_out_ff, f_out_in;

   assign ft_s     = psu_pkg::ft_signed(cfg.frame_time);
   assign valid_in = {valid_ff[psu_pkg::MOT_LAT-2:0], in_valid};

   // gravity times weight
   assign a_req_in   = req;
   assign a_gprod_in = cfg.gravity * req.weight;

   // scaled gravity times frame, horizontal displacements
   assign b_gw        = psu_pkg::floor_sat(a_gprod_ff);
   assign b_req_in    = a_req_ff;
   assign b_dvprod_in = b_gw * ft_s;
   assign b_dxprod_in = a_req_ff.vel_x * ft_s;
   assign b_dzprod_in = a_req_ff.vel_z * ft_s;

   // new vertical velocity
   assign c_req_in  = b_req_ff;
   assign c_vely_in = psu_pkg::sat_s32(64'(b_req_ff.vel_y)
                                       + 64'(psu_pkg::floor_sat(b_dvprod_ff)));
   assign c_dx_in   = psu_pkg::floor_sat(b_dxprod_ff);
   assign c_dz_in   = psu_pkg::floor_sat(b_dzprod_ff);

   // move x and z, start vertical displacement
   assign d_yprod_in = c_vely_ff * ft_s;
   assign d_vely_in  = c_vely_ff;
   assign d_px_in    = psu_pkg::sat_s32(64'(c_req_ff.pos_x) + 64'(c_dx_ff));
   assign d_pz_in    = psu_pkg::sat_s32(64'(c_req_ff.pos_z) + 64'(c_dz_ff));
   assign d_tx_in    = psu_pkg::sat_s32(64'(c_req_ff.tgt_x) + 64'(c_dx_ff)
                                        + 64'(cfg.emit_x));
   assign d_tz_in    = psu_pkg::sat_s32(64'(c_req_ff.tgt_z) + 64'(c_dz_ff)
                                        + 64'(cfg.emit_z));
   assign d_posy_in  = c_req_ff.pos_y;
   assign d_tgty_in  = c_req_ff.tgt_y;

   assign e_dy_in   = psu_pkg::floor_sat(d_yprod_ff);
   assign e_vely_in = d_vely_ff;
   assign e_px_in   = d_px_ff;
   assign e_pz_in   = d_pz_ff;
   assign e_tx_in   = d_tx_ff;
   assign e_tz_in   = d_tz_ff;
   assign e_posy_in = d_posy_ff;
   assign e_tgty_in = d_tgty_ff;

   always_comb begin
      f_out_in.p_x   = e_px_ff;
      f_out_in.p_z   = e_pz_ff;
      f_out_in.t_x   = e_tx_ff;
      f_out_in.t_z   = e_tz_ff;
      f_out_in.vel_y = e_vely_ff;
      f_out_in.p_y   = psu_pkg::sat_s32(64'(e_posy_ff) + 64'(e_dy_ff));
      f_out_in.t_y   = psu_pkg::sat_s32(64'(e_tgty_ff) + 64'(e_dy_ff) + 64'(cfg.emit_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff    <= a_req_in;
      a_gprod_ff  <= a_gprod_in;
      b_req_ff    <= b_req_in;
      b_dvprod_ff <= b_dvprod_in;
      b_dxprod_ff <= b_dxprod_in;
      b_dzprod_ff <= b_dzprod_in;
      c_req_ff    <= c_req_in;
      c_vely_ff   <= c_vely_in;
      c_dx_ff     <= c_dx_in;
      c_dz_ff     <= c_dz_in;
      d_yprod_ff  <= d_yprod_in;
      d_vely_ff   <= d_vely_in;
      d_px_ff     <= d_px_in;
      d_pz_ff     <= d_pz_in;
      d_tx_ff     <= d_tx_in;
      d_tz_ff     <= d_tz_in;
      d_posy_ff   <= d_posy_in;
      d_tgty_ff   <= d_tgty_in;
      e_dy_ff     <= e_dy_in;
      e_vely_ff   <= e_vely_in;
      e_px_ff     <= e_px_in;
      e_pz_ff     <= e_pz_in;
      e_tx_ff     <= e_tx_in;
      e_tz_ff     <= e_tz_in;
      e_posy_ff   <= e_posy_in;
      e_tgty_ff   <= e_tgty_in;
      f_out_ff    <= f_out_in;
   end

   assign out_valid = valid_ff[psu_pkg::MOT_LAT-1];
   assign out       = f_out_ff;

endmodule

// ===== hdl/psu_div.sv =====
// ----------------------------------------------------------------------------
// psu_div
// Elapsed time update and pipelined restoring divider, one quotient bit per
// stage, then the clamped blend factor.
// ----------------------------------------------------------------------------
module psu_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [30:0]          elapsed_in,
   input  logic [30:0]          life,
   input  logic [30:0]          frame_time,
   output logic                 out_valid,
   output psu_pkg::psu_time_type out
);

   localparam int QW = psu_pkg::Q_W;
   localparam int FB = psu_pkg::FRAC_BITS;

   logic [QW+1:0] valid_ff, valid_in;
   logic [30:0]   rem_ff   [0:QW];
   logic [30:0]   rem_in   [0:QW];
   logic [QW-1:0] num_ff   [0:QW];
   logic [QW-1:0] num_in   [0:QW];
   logic [QW-1:0] q_ff     [0:QW];
   logic [QW-1:0] q_in     [0:QW];
   logic [30:0]   life_ff  [0:QW];
   logic [30:0]   life_in  [0:QW];
   logic [30:0]   el_ff    [0:QW];
   logic [30:0]   el_in    [0:QW];
   logic          alive_ff [0:QW];
   logic          alive_in [0:QW];
   logic          ovf_ff   [0:QW];
   logic          ovf_in   [0:QW];

   logic [31:0]        sum;
   logic [30:0]        el0;
   logic [32:0]        k_val;
   logic signed [33:0] diff;
   psu_pkg::psu_time_type out_ff, out_in;

   always_comb begin
      logic [QW-1:0] t;
      logic          ge;
      sum = {1'b0, elapsed_in} + {1'b0, frame_time};
      el0 = sum[31] ? '1 : sum[30:0];
      // quotient would reach 2^QW: blend factor is zero, zero lifetime too
      ovf_in[0]   = 64'(el0) >= (64'(life) << (QW - FB));
      rem_in[0]   = 31'(el0 >> (QW - FB));
      num_in[0]   = QW'(el0) << FB;
      q_in[0]     = '0;
      life_in[0]  = life;
      el_in[0]    = el0;
      alive_in[0] = el0 < life;
      for (int k = 1; k <= QW; k++) begin
         t           = {rem_ff[k-1], num_ff[k-1][QW-1]};
         ge          = t >= {1'b0, life_ff[k-1]};
         rem_in[k]   = ge ? 31'(t - {1'b0, life_ff[k-1]}) : t[30:0];
         num_in[k]   = num_ff[k-1] << 1;
         q_in[k]     = {q_ff[k-1][QW-2:0], ge};
         life_in[k]  = life_ff[k-1];
         el_in[k]    = el_ff[k-1];
         alive_in[k] = alive_ff[k-1];
         ovf_in[k]   = ovf_ff[k-1];
      end
   end

   always_comb begin
      k_val = 33'(frame_time) + (33'(1) << FB);
      diff  = $signed({1'b0, k_val}) - $signed({2'b0, q_ff[QW]});
      out_in.elapsed = el_ff[QW];
      out_in.alive   = alive_ff[QW];
      if (ovf_ff[QW] || diff < 0) begin
         out_in.alpha = '0;
      end else if (diff > $signed(34'(psu_pkg::ALPHA_ONE))) begin
         out_in.alpha = psu_pkg::ALPHA_ONE;
      end else begin
         out_in.alpha = diff[psu_pkg::ALPHA_W-1:0];
      end
   end

   assign valid_in = {valid_ff[QW:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QW; k++) begin
         rem_ff[k]   <= rem_in[k];
         num_ff[k]   <= num_in[k];
         q_ff[k]     <= q_in[k];
         life_ff[k]  <= life_in[k];
         el_ff[k]    <= el_in[k];
         alive_ff[k] <= alive_in[k];
         ovf_ff[k]   <= ovf_in[k];
      end
      out_ff <= out_in;
   end

   assign out_valid = valid_ff[QW+1];
   assign out       = out_ff;

endmodule

// ===== hdl/psu_blend.sv =====
// ----------------------------------------------------------------------------
// psu_blend
// Three-stage blend of the moved position toward the moved target.
// ----------------------------------------------------------------------------
module psu_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  psu_pkg::psu_motion_type mot,
   input  psu_pkg::psu_time_type   tim,
   output logic                    out_valid,
   output psu_pkg::psu_rsp_type    rsp
);

   localparam int PW = psu_pkg::PROD_W;

   logic [psu_pkg::BLEND_LAT-1:0] valid_ff, valid_in;
   logic signed [31:0] p_cur [3];
   logic signed [31:0] t_cur [3];
   logic signed [32:0] diff_ff [3];
   logic signed [32:0] diff_in [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [PW-1:0] prod_in [3];
   logic signed [31:0] np_in [3];
   psu_pkg::psu_motion_type mot1_ff, mot2_ff;
   psu_pkg::psu_time_type   tim1_ff, tim2_ff;
   psu_pkg::psu_rsp_type    rsp_ff, rsp_in;

   assign p_cur = '{mot.p_x, mot.p_y, mot.p_z};
   assign t_cur = '{mot.t_x, mot.t_y, mot.t_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 33'(t_cur[i]) - 33'(p_cur[i]);
         prod_in[i] = diff_ff[i] * $signed({1'b0, tim1_ff.alpha});
      end
      np_in[0] = psu_pkg::sat_s32(64'(mot2_ff.p_x) + 64'(prod_ff[0] >>> psu_pkg::FRAC_BITS));
      np_in[1] = psu_pkg::sat_s32(64'(mot2_ff.p_y) + 64'(prod_ff[1] >>> psu_pkg::FRAC_BITS));
      np_in[2] = psu_pkg::sat_s32(64'(mot2_ff.p_z) + 64'(prod_ff[2] >>> psu_pkg::FRAC_BITS));
      rsp_in.pos_x   = np_in[0];
      rsp_in.pos_y   = np_in[1];
      rsp_in.pos_z   = np_in[2];
      rsp_in.tgt_x   = mot2_ff.t_x;
      rsp_in.tgt_y   = mot2_ff.t_y;
      rsp_in.tgt_z   = mot2_ff.t_z;
      rsp_in.vel_y   = mot2_ff.vel_y;
      rsp_in.elapsed = tim2_ff.elapsed;
      rsp_in.alive   = tim2_ff.alive;
   end

   assign valid_in = {valid_ff[psu_pkg::BLEND_LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         diff_ff[i] <= diff_in[i];
         prod_ff[i] <= prod_in[i];
      end
      mot1_ff <= mot;
      mot2_ff <= mot1_ff;
      tim1_ff <= tim;
      tim2_ff <= tim1_ff;
      rsp_ff  <= rsp_in;
   end

   assign out_valid = valid_ff[psu_pkg::BLEND_LAT-1];
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/particle_state_update_core.sv =====
// ----------------------------------------------------------------------------
// particle_state_update_core
// One-frame fixed-point particle update: gravity, motion, target drift and
// lifetime-weighted blend of position toward target.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   req_*  (12 fields)       start, busy (busy never rises)
//  response  rsp_*  (9 fields)        rsp_valid, one-cycle strobe
//  config    csr_we, csr_index, csr_wdata   write on csr_we
//
//  One word accepted per cycle; each result passes the elapsed-time update,
//  the 32-stage quotient divider and the clamped blend factor, then the blend.
//  Motion results wait in a 28-stage align line for the divider.
//  Synchronous reset clears valid bits and reloads the register defaults.
//  Results are strobed once and not held.
// ----------------------------------------------------------------------------
module particle_state_update_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [30:0]        req_elapsed_in,
   input  logic [30:0]        req_life_span,
   input  logic signed [31:0] req_gravity_weight,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_target_x,
   output logic signed [31:0] rsp_new_target_y,
   output logic signed [31:0] rsp_new_target_z,
   output logic signed [31:0] rsp_new_vel_y,
   output logic [30:0]        rsp_elapsed_out,
   output logic               rsp_alive,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AL = psu_pkg::ALIGN_LAT;

   psu_pkg::psu_cfg_type    cfg_ff, cfg_in;
   psu_pkg::psu_req_type    req;
   psu_pkg::psu_motion_type mot;
   psu_pkg::psu_time_type   tim;
   psu_pkg::psu_rsp_type    rsp;
   psu_pkg::psu_motion_type mdly_ff [AL];
   psu_pkg::psu_motion_type mdly_in [AL];
   logic [AL-1:0] mvalid_ff, mvalid_in;
   logic accept, mot_valid, tim_valid;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            psu_pkg::CSR_FRAME_TIME: cfg_in.frame_time = csr_wdata[30:0];
            psu_pkg::CSR_GRAVITY:    cfg_in.gravity    = csr_wdata;
            psu_pkg::CSR_EMIT_X:     cfg_in.emit_x     = csr_wdata;
            psu_pkg::CSR_EMIT_Y:     cfg_in.emit_y     = csr_wdata;
            psu_pkg::CSR_EMIT_Z:     cfg_in.emit_z     = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_time <= psu_pkg::FRAME_TIME_RST;
         cfg_ff.gravity    <= psu_pkg::GRAVITY_RST;
         cfg_ff.emit_x     <= '0;
         cfg_ff.emit_y     <= '0;
         cfg_ff.emit_z     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req.pos_x   = req_pos_x;
      req.pos_y   = req_pos_y;
      req.pos_z   = req_pos_z;
      req.tgt_x   = req_target_x;
      req.tgt_y   = req_target_y;
      req.tgt_z   = req_target_z;
      req.vel_x   = req_vel_x;
      req.vel_y   = req_vel_y;
      req.vel_z   = req_vel_z;
      req.elapsed = req_elapsed_in;
      req.life    = req_life_span;
      req.weight  = req_gravity_weight;
   end

   psu_motion u_motion (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .req       (req),
      .cfg       (cfg_ff),
      .out_valid (mot_valid),
      .out       (mot)
   );

   psu_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .elapsed_in (req_elapsed_in),
      .life       (req_life_span),
      .frame_time (cfg_ff.frame_time),
      .out_valid  (tim_valid),
      .out        (tim)
   );

   // hold motion words until the divider catches up
   always_comb begin
      mdly_in[0]   = mot;
      mvalid_in[0] = mot_valid;
      for (int i = 1; i < AL; i++) begin
         mdly_in[i]   = mdly_ff[i-1];
         mvalid_in[i] = mvalid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= '0;
      end else begin
         mvalid_ff <= mvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < AL; i++) begin
         mdly_ff[i] <= mdly_in[i];
      end
   end

   psu_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tim_valid),
      .mot       (mdly_ff[AL-1]),
      .tim       (tim),
      .out_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_new_pos_x    = rsp.pos_x;
   assign rsp_new_pos_y    = rsp.pos_y;
   assign rsp_new_pos_z    = rsp.pos_z;
   assign rsp_new_target_x = rsp.tgt_x;
   assign rsp_new_target_y = rsp.tgt_y;
   assign rsp_new_target_z = rsp.tgt_z;
   assign rsp_new_vel_y    = rsp.vel_y;
   assign rsp_elapsed_out  = rsp.elapsed;
   assign rsp_alive        = rsp.alive;

   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy && !reset, psu_pkg::TOTAL_LAT))
      else $error("response strobe out of step with accepted requests");

   a_align: assert property (@(posedge clock) disable iff (reset)
      tim_valid == mvalid_ff[AL-1])
      else $error("motion and divider words misaligned");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      tim_valid |-> tim.alpha <= psu_pkg::ALPHA_ONE)
      else $error("blend factor above one");

   a_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alive |-> rsp_elapsed_out != 31'h7FFFFFFF)
      else $error("alive with saturated elapsed time");

endmodule

// ===== verif/particle_state_update_checker.sv =====
// ----------------------------------------------------------------------------
// particle_state_update_checker
// Watches the request, response and register ports of the particle update
// core, predicts each updated particle state from a local copy of the
// registers and compares responses in order against the predictions.
// ----------------------------------------------------------------------------
module particle_state_update_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  psu_pkg::psu_req_type req_word,
   input  logic                 rsp_valid,
   input  psu_pkg::psu_rsp_type rsp_word,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;

   psu_pkg::psu_cfg_type regs;
   psu_pkg::psu_rsp_type state_q[$];

   function automatic longint clamp32(input longint v);
      if (v > S32_HI) begin
         return S32_HI;
      end
      if (v < S32_LO) begin
         return S32_LO;
      end
      return v;
   endfunction

   function automatic psu_pkg::psu_rsp_type advance_particle(
      input psu_pkg::psu_cfg_type c,
      input psu_pkg::psu_req_type r);
      longint ft, el, life, gw, dv, vy, alpha, ratio, d;
      longint pos[3], tgt[3], vel[3], emit[3], p[3], nt[3], np[3];
      psu_pkg::psu_rsp_type o;
      ft      = longint'(c.frame_time);
      life    = longint'(r.life);
      pos[0]  = longint'(r.pos_x);
      pos[1]  = longint'(r.pos_y);
      pos[2]  = longint'(r.pos_z);
      tgt[0]  = longint'(r.tgt_x);
      tgt[1]  = longint'(r.tgt_y);
      tgt[2]  = longint'(r.tgt_z);
      vel[0]  = longint'(r.vel_x);
      vel[2]  = longint'(r.vel_z);
      emit[0] = longint'(c.emit_x);
      emit[1] = longint'(c.emit_y);
      emit[2] = longint'(c.emit_z);

      el = longint'(r.elapsed) + ft;
      if (el > S32_HI) begin
         el = S32_HI;
      end
      gw = clamp32((longint'(c.gravity) * longint'(r.weight)) >>> psu_pkg::FRAC_BITS);
      dv = clamp32((gw * ft) >>> psu_pkg::FRAC_BITS);
      vy = clamp32(longint'(r.vel_y) + dv);
      vel[1] = vy;

      for (int i = 0; i < 3; i++) begin
         d     = clamp32((vel[i] * ft) >>> psu_pkg::FRAC_BITS);
         p[i]  = clamp32(pos[i] + d);
         nt[i] = clamp32(tgt[i] + d + emit[i]);
      end

      // zero lifetime: no blend toward target
      if (life == 0) begin
         alpha = 0;
      end else begin
         ratio = (el << psu_pkg::FRAC_BITS) / life;
         alpha = ft + (64'sd1 << psu_pkg::FRAC_BITS) - ratio;
         if (alpha < 0) begin
            alpha = 0;
         end
         if (alpha > (64'sd1 << psu_pkg::FRAC_BITS)) begin
            alpha = 64'sd1 << psu_pkg::FRAC_BITS;
         end
      end

      for (int i = 0; i < 3; i++) begin
         np[i] = clamp32(p[i] + (((nt[i] - p[i]) * alpha) >>> psu_pkg::FRAC_BITS));
      end

      o.pos_x   = np[0][31:0];
      o.pos_y   = np[1][31:0];
      o.pos_z   = np[2][31:0];
      o.tgt_x   = nt[0][31:0];
      o.tgt_y   = nt[1][31:0];
      o.tgt_z   = nt[2][31:0];
      o.vel_y   = vy[31:0];
      o.elapsed = el[30:0];
      o.alive   = (el < life);
      return o;
   endfunction

   assign pending = state_q.size();

   always_ff @(posedge clock) begin
      psu_pkg::psu_rsp_type want;
      if (reset) begin
         regs.frame_time <= psu_pkg::FRAME_TIME_RST;
         regs.gravity    <= psu_pkg::GRAVITY_RST;
         regs.emit_x     <= '0;
         regs.emit_y     <= '0;
         regs.emit_z     <= '0;
         fail_count      <= 0;
         state_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               psu_pkg::CSR_FRAME_TIME: begin
                  regs.frame_time <= csr_wdata[30:0];
               end
               psu_pkg::CSR_GRAVITY: begin
                  regs.gravity <= csr_wdata;
               end
               psu_pkg::CSR_EMIT_X: begin
                  regs.emit_x <= csr_wdata;
               end
               psu_pkg::CSR_EMIT_Y: begin
                  regs.emit_y <= csr_wdata;
               end
               psu_pkg::CSR_EMIT_Z: begin
                  regs.emit_z <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid) begin
            if (state_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) begin
                  $display("unexpected response word at %0t", $realtime);
               end
            end else begin
               want = state_q.pop_front();
               if (rsp_word !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  pos exp %h %h %h got %h %h %h", want.pos_x,
                              want.pos_y, want.pos_z, rsp_word.pos_x,
                              rsp_word.pos_y, rsp_word.pos_z);
                     $display("  tgt exp %h %h %h got %h %h %h", want.tgt_x,
                              want.tgt_y, want.tgt_z, rsp_word.tgt_x,
                              rsp_word.tgt_y, rsp_word.tgt_z);
                     $display("  vel_y exp %h got %h, elapsed exp %h got %h",
                              want.vel_y, rsp_word.vel_y, want.elapsed,
                              rsp_word.elapsed);
                     $display("  alive exp %b got %b", want.alive,
                              rsp_word.alive);
                  end
               end
            end
         end
         if (start && !busy) begin
            state_q.push_back(advance_particle(regs, req_word));
         end
      end
   end

endmodule

// ===== verif/particle_state_update_core_tb.sv =====
// ----------------------------------------------------------------------------
// particle_state_update_core_tb
// Drives particle update words in random bursts across several register
// settings; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module particle_state_update_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 5000;
   localparam int PHASES   = 9;
   localparam int PER_PHASE = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   psu_pkg::psu_req_type req_word = '0;
   logic                 rsp_valid;
   psu_pkg::psu_rsp_type rsp_word;
   logic                 csr_we = 1'b0;
   logic [2:0]           csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   int                   fail_count;
   int                   pending;
   int                   idle_cycles = 0;
   int                   burst_left = 0;

   always #5 clock = ~clock;

   particle_state_update_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_pos_x          (req_word.pos_x),
      .req_pos_y          (req_word.pos_y),
      .req_pos_z          (req_word.pos_z),
      .req_target_x       (req_word.tgt_x),
      .req_target_y       (req_word.tgt_y),
      .req_target_z       (req_word.tgt_z),
      .req_vel_x          (req_word.vel_x),
      .req_vel_y          (req_word.vel_y),
      .req_vel_z          (req_word.vel_z),
      .req_elapsed_in     (req_word.elapsed),
      .req_life_span      (req_word.life),
      .req_gravity_weight (req_word.weight),
      .rsp_valid          (rsp_valid),
      .rsp_new_pos_x      (rsp_word.pos_x),
      .rsp_new_pos_y      (rsp_word.pos_y),
      .rsp_new_pos_z      (rsp_word.pos_z),
      .rsp_new_target_x   (rsp_word.tgt_x),
      .rsp_new_target_y   (rsp_word.tgt_y),
      .rsp_new_target_z   (rsp_word.tgt_z),
      .rsp_new_vel_y      (rsp_word.vel_y),
      .rsp_elapsed_out    (rsp_word.elapsed),
      .rsp_alive          (rsp_word.alive),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   particle_state_update_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [31:0] near(input int bits);
      return $signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
   endfunction

   function automatic psu_pkg::psu_req_type noise_word();
      psu_pkg::psu_req_type w;
      w.pos_x   = $urandom;
      w.pos_y   = $urandom;
      w.pos_z   = $urandom;
      w.tgt_x   = $urandom;
      w.tgt_y   = $urandom;
      w.tgt_z   = $urandom;
      w.vel_x   = $urandom;
      w.vel_y   = $urandom;
      w.vel_z   = $urandom;
      w.elapsed = 31'($urandom);
      w.life    = 31'($urandom);
      w.weight  = $urandom;
      return w;
   endfunction

   // live particle: modest magnitudes, elapsed mostly inside its lifetime
   function automatic psu_pkg::psu_req_type live_word();
      psu_pkg::psu_req_type w;
      w.pos_x   = near(25);
      w.pos_y   = near(25);
      w.pos_z   = near(25);
      w.tgt_x   = near(25);
      w.tgt_y   = near(25);
      w.tgt_z   = near(25);
      w.vel_x   = near(22);
      w.vel_y   = near(22);
      w.vel_z   = near(22);
      w.weight  = near(18);
      w.life    = 31'($urandom_range(1, 1 << 22));
      w.elapsed = 31'($urandom_range(0, 32'(w.life) + 32'd4096));
      return w;
   endfunction

   task automatic push(input psu_pkg::psu_req_type w);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_regs(input logic [31:0] ft, input logic [31:0] grav,
                            input logic [31:0] ex, input logic [31:0] ey,
                            input logic [31:0] ez);
      csr_write(psu_pkg::CSR_FRAME_TIME, ft);
      csr_write(psu_pkg::CSR_GRAVITY, grav);
      csr_write(psu_pkg::CSR_EMIT_X, ex);
      csr_write(psu_pkg::CSR_EMIT_Y, ey);
      csr_write(psu_pkg::CSR_EMIT_Z, ez);
      // unmapped index: must be dropped
      csr_write(3'(psu_pkg::CSR_EMIT_Z + $urandom_range(1, 3)), $urandom);
   endtask

   initial begin
      psu_pkg::psu_req_type w;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under reset register values
      push('0);
      w = '1;
      w.pos_x = 32'sh7FFFFFFF; w.pos_y = 32'sh7FFFFFFF; w.pos_z = 32'sh7FFFFFFF;
      w.tgt_x = 32'sh7FFFFFFF; w.tgt_y = 32'sh7FFFFFFF; w.tgt_z = 32'sh7FFFFFFF;
      w.vel_x = 32'sh7FFFFFFF; w.vel_y = 32'sh7FFFFFFF; w.vel_z = 32'sh7FFFFFFF;
      w.weight = 32'sh7FFFFFFF;
      push(w);
      w = '0;
      w.pos_x = 32'sh80000000; w.pos_y = 32'sh80000000; w.pos_z = 32'sh80000000;
      w.tgt_x = 32'sh80000000; w.tgt_y = 32'sh80000000; w.tgt_z = 32'sh80000000;
      w.vel_x = 32'sh80000000; w.vel_y = 32'sh80000000; w.vel_z = 32'sh80000000;
      w.weight = 32'sh80000000; w.life = '1;
      push(w);
      w = live_word(); w.life = '0;
      push(w);
      w = live_word(); w.elapsed = '1;
      push(w);
      w = live_word(); w.elapsed = w.life - 31'd1092;
      push(w);
      w = live_word(); w.elapsed = w.life - 31'd1093;
      push(w);
      w = live_word(); w.elapsed = '0; w.life = 31'd1;
      push(w);
      w = live_word(); w.pos_x = 32'sh7FFFFF00; w.tgt_y = 32'sh80000010;
      w.vel_x = 32'sh7FFFFFFF; w.vel_y = 32'sh80000000;
      push(w);
      w = live_word(); w.tgt_x = 32'sh7FFFFFF0; w.pos_x = 32'sh80000000;
      w.elapsed = '0;
      push(w);
      for (int i = 0; i < 8; i++) begin
         push(live_word());
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: load_regs(32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF);
            1: load_regs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000);
            2: load_regs(32'h00010000, $urandom, $urandom, $urandom, $urandom);
            default: load_regs($urandom_range(0, 8192), near(22), near(18),
                               near(18), near(18));
         endcase
         for (int i = 0; i < PER_PHASE; i++) begin
            if ($urandom_range(0, 9) < 7) begin
               push(live_word());
            end else begin
               push(noise_word());
            end
         end
         // hold off until every response is back before touching registers
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
